FILE: src/sbc_pkg.sv
// Package for the swept box collision step core.
// Payload structs, item kinds, register indexes and fixed-point constants.
// No dependencies.
package sbc_pkg;

	localparam int POS_W = 24;
	localparam int SIZE_W = 16;
	localparam int TIME_W = 16;
	localparam int DIST_W = 26;
	localparam int DMAG_W = 25;
	localparam int DIVD_W = DMAG_W + TIME_W;
	localparam int TQ_W = 44;
	localparam int CFG_IDX_W = 3;

	localparam logic [1:0] KIND_SET_VEL = 2'd0;
	localparam logic [1:0] KIND_COLLIDE = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;
	localparam logic [1:0] KIND_SPARE   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_LEFT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_TOP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_THR   = 3'd4;

	localparam logic [SIZE_W-1:0] BOX_SIZE_RST = 16'd4096;
	localparam logic [TIME_W-1:0] STOP_THR_RST = 16'd66;
	localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;
	localparam logic signed [TQ_W-1:0] TIME_INF = 44'sh400_0000_0000;
	localparam logic signed [POS_W-1:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 24'sh800000;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [POS_W-1:0] new_vel_x;
		logic signed [POS_W-1:0] new_vel_y;
		logic signed [POS_W-1:0] other_left;
		logic signed [POS_W-1:0] other_top;
		logic [SIZE_W-1:0]       other_width;
		logic [SIZE_W-1:0]       other_height;
		logic [TIME_W-1:0]       step_time;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_left;
		logic signed [POS_W-1:0] pos_top;
		logic signed [POS_W-1:0] vel_x_out;
		logic signed [POS_W-1:0] vel_y_out;
		logic                    on_ground;
		logic                    hit;
	} out_item_t;

endpackage

FILE: src/swept_box_collision_step_core.sv
// Swept box collision step core: one moving box, set velocity / collide / tick items.
// Holds a bit-serial restoring divider for the swept entry times.
// Depends on sbc_pkg.
//
// Usage: items enter on in_valid/in_ready, one at a time; each item gives exactly one
// result transfer on out_valid/out_ready. Configuration writes go on cfg_valid/cfg_ready
// (always ready) with a register index and data; the user must make writes only while
// idle, as the core itself does not enforce this. Set velocity and unused kinds go
// straight to output; tick moves the X axis, then the Y axis, through the shared
// multiplier; collide runs four entry-time divisions, one quotient bit per cycle in a
// single restoring divider, each set up in its own step, plus accept, compare and
// output steps. Axes with zero velocity skip their divisions. The next item is taken
// once the result has been moved to the output register, so a result may wait at the
// output while a new item is accepted.
// Reset: position loads the start registers (0,0), velocity zero, limits maximum,
// grounded clear, box 4096 by 4096, stop threshold 66. A stalled receiver holds the
// result in the output register; a finished item waits until that register frees.
module swept_box_collision_step_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  sbc_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output sbc_pkg::out_item_t               out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sbc_pkg::POS_W-1:0]        cfg_data
);
	import sbc_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_PREP = 7'b0000010,
		S_DIV  = 7'b0000100,
		S_EVAL = 7'b0001000,
		S_MOVX = 7'b0010000,
		S_MOVY = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	in_item_t item_q;
	out_item_t out_q;
	logic out_valid_q;

	logic [SIZE_W-1:0] box_w_q, box_h_q, thr_q;
	logic signed [POS_W-1:0] start_left_q, start_top_q;
	logic signed [POS_W-1:0] left_q, top_q, velx_q, vely_q;
	logic [TIME_W-1:0] limx_q, limy_q;
	logic gnd_q, hit_q, miss_q;

	logic signed [TQ_W-1:0] t_q [4];
	logic [1:0] op_q;
	logic [5:0] cnt_q;
	logic [DIVD_W-1:0] dq_q;
	logic [POS_W-1:0] rem_q, dvs_q;
	logic qneg_q;

	assign in_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// distances per axis
	logic signed [DIST_W-1:0] dlo_x, dhi_x, dlo_y, dhi_y, p_dlo, p_dhi, p_d;
	logic signed [POS_W-1:0] p_v;
	logic [DMAG_W-1:0] p_dmag;
	logic [POS_W-1:0] p_vmag;

	always_comb begin
		dlo_x = DIST_W'(item_q.other_left) - DIST_W'(left_q) - DIST_W'({1'b0, box_w_q});
		dhi_x = DIST_W'(item_q.other_left) + DIST_W'({1'b0, item_q.other_width})
			- DIST_W'(left_q);
		dlo_y = DIST_W'(item_q.other_top) - DIST_W'(top_q) - DIST_W'({1'b0, box_h_q});
		dhi_y = DIST_W'(item_q.other_top) + DIST_W'({1'b0, item_q.other_height})
			- DIST_W'(top_q);
		p_dlo = op_q[1] ? dlo_y : dlo_x;
		p_dhi = op_q[1] ? dhi_y : dhi_x;
		p_d = op_q[0] ? p_dhi : p_dlo;
		p_v = op_q[1] ? vely_q : velx_q;
		p_dmag = p_d[DIST_W-1] ? DMAG_W'(-p_d) : DMAG_W'(p_d);
		p_vmag = p_v[POS_W-1] ? POS_W'(-p_v) : POS_W'(p_v);
	end

	// divider step
	logic [POS_W:0] dv_shift;
	logic [POS_W+1:0] dv_diff;
	logic dv_ge;
	logic [DIVD_W-1:0] dv_quot;
	logic signed [TQ_W-1:0] dv_res;

	always_comb begin
		dv_shift = {rem_q, dq_q[DIVD_W-1]};
		dv_diff = {1'b0, dv_shift} - {2'b00, dvs_q};
		dv_ge = !dv_diff[POS_W+1];
		dv_quot = {dq_q[DIVD_W-2:0], dv_ge};
		dv_res = qneg_q ? -TQ_W'(dv_quot) : TQ_W'(dv_quot);
	end

	// hit evaluation
	logic signed [TQ_W-1:0] nx, fx, ny, fy, fmin, near_t, cl_t;
	logic ev_miss, ev_xaxis;
	logic [TIME_W-1:0] ev_lim, ev_new;

	always_comb begin
		nx = velx_q[POS_W-1] ? t_q[1] : t_q[0];
		fx = velx_q[POS_W-1] ? t_q[0] : t_q[1];
		ny = vely_q[POS_W-1] ? t_q[3] : t_q[2];
		fy = vely_q[POS_W-1] ? t_q[2] : t_q[3];
		fmin = (fx < fy) ? fx : fy;
		ev_miss = miss_q || (nx > fy) || (ny > fx) || (fmin <= 0);
		ev_xaxis = nx > ny;
		near_t = ev_xaxis ? nx : ny;
		ev_lim = ev_xaxis ? limx_q : limy_q;
		cl_t = (near_t < $signed({{(TQ_W-TIME_W){1'b0}}, ev_lim}))
			? near_t : $signed({{(TQ_W-TIME_W){1'b0}}, ev_lim});
		ev_new = (cl_t < 0) ? '0 : cl_t[TIME_W-1:0];
	end

	// motion, one axis per cycle
	logic mv_y;
	logic signed [POS_W-1:0] mv_pos, mv_vel, mv_res;
	logic [TIME_W-1:0] mv_lim, mv_m;
	logic [POS_W-1:0] mv_vmag;
	logic [POS_W+TIME_W-1:0] mv_prod;
	logic [POS_W+TIME_W:0] mv_rnd;
	logic [POS_W:0] mv_delta;
	logic signed [POS_W+1:0] mv_sdelta;
	logic signed [POS_W+2:0] mv_sum;

	always_comb begin
		mv_y = (state_q == S_MOVY);
		mv_pos = mv_y ? top_q : left_q;
		mv_vel = mv_y ? vely_q : velx_q;
		mv_lim = mv_y ? limy_q : limx_q;
		mv_m = (item_q.step_time < mv_lim) ? item_q.step_time : mv_lim;
		mv_vmag = mv_vel[POS_W-1] ? POS_W'(-mv_vel) : POS_W'(mv_vel);
		mv_prod = mv_vmag * mv_m;
		mv_rnd = {1'b0, mv_prod} + (POS_W+TIME_W+1)'(32768);
		mv_delta = mv_rnd[POS_W+TIME_W:TIME_W];
		mv_sdelta = mv_vel[POS_W-1] ? -$signed({1'b0, mv_delta}) : $signed({1'b0, mv_delta});
		mv_sum = (POS_W+3)'(mv_pos) + (POS_W+3)'(mv_sdelta);
		if (mv_sum > (POS_W+3)'(POS_MAX))
			mv_res = POS_MAX;
		else if (mv_sum < (POS_W+3)'(POS_MIN))
			mv_res = POS_MIN;
		else
			mv_res = mv_sum[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			box_w_q <= BOX_SIZE_RST;
			box_h_q <= BOX_SIZE_RST;
			start_left_q <= '0;
			start_top_q <= '0;
			thr_q <= STOP_THR_RST;
			left_q <= '0;
			top_q <= '0;
			velx_q <= '0;
			vely_q <= '0;
			limx_q <= TIME_MAX;
			limy_q <= TIME_MAX;
			gnd_q <= 1'b0;
			hit_q <= 1'b0;
			miss_q <= 1'b0;
			op_q <= '0;
			cnt_q <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						hit_q <= 1'b0;
						miss_q <= 1'b0;
						op_q <= '0;
						case (in_data.kind)
							KIND_SET_VEL: begin
								velx_q <= in_data.new_vel_x;
								vely_q <= in_data.new_vel_y;
								state_q <= S_DONE;
							end
							KIND_COLLIDE: state_q <= S_PREP;
							KIND_TICK: state_q <= S_MOVX;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PREP: begin
					if (p_v == 0) begin
						t_q[op_q] <= op_q[0] ? TIME_INF : -TIME_INF;
						if (!op_q[0] && !(p_dlo < 0 && p_dhi > 0))
							miss_q <= 1'b1;
						op_q <= op_q + 2'd1;
						if (op_q == 2'd3)
							state_q <= S_EVAL;
					end else begin
						dq_q <= {p_dmag, {TIME_W{1'b0}}};
						rem_q <= '0;
						dvs_q <= p_vmag;
						qneg_q <= p_d[DIST_W-1] ^ p_v[POS_W-1];
						cnt_q <= 6'(DIVD_W - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= dv_ge ? dv_diff[POS_W-1:0] : dv_shift[POS_W-1:0];
					dq_q <= dv_quot;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						t_q[op_q] <= dv_res;
						op_q <= op_q + 2'd1;
						state_q <= (op_q == 2'd3) ? S_EVAL : S_PREP;
					end
				end
				S_EVAL: begin
					hit_q <= !ev_miss;
					if (!ev_miss) begin
						if (ev_xaxis) begin
							limx_q <= ev_new;
							if (ev_new < thr_q)
								velx_q <= '0;
						end else begin
							limy_q <= ev_new;
							if (ev_new < thr_q) begin
								vely_q <= '0;
								if (!vely_q[POS_W-1])
									gnd_q <= 1'b1;
							end
						end
					end
					state_q <= S_DONE;
				end
				S_MOVX: begin
					left_q <= mv_res;
					state_q <= S_MOVY;
				end
				S_MOVY: begin
					top_q <= mv_res;
					limx_q <= TIME_MAX;
					limy_q <= TIME_MAX;
					gnd_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q.pos_left <= left_q;
						out_q.pos_top <= top_q;
						out_q.vel_x_out <= velx_q;
						out_q.vel_y_out <= vely_q;
						out_q.on_ground <= gnd_q;
						out_q.hit <= hit_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_BOX_WIDTH: box_w_q <= cfg_data[SIZE_W-1:0];
					REG_BOX_HEIGHT: box_h_q <= cfg_data[SIZE_W-1:0];
					REG_START_LEFT: begin
						start_left_q <= cfg_data;
						left_q <= cfg_data;
					end
					REG_START_TOP: begin
						start_top_q <= cfg_data;
						top_q <= cfg_data;
					end
					REG_STOP_THR: thr_q <= cfg_data[TIME_W-1:0];
					default: ;
				endcase
			end
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dvs_q != '0)
		else $error("divider running with zero divisor");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted item did not start");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("finished result not presented");

	a_hit_only_collide: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q && state_q == S_DONE |-> item_q.kind == KIND_COLLIDE)
		else $error("hit flagged for non-collide item");

	a_start_regs: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_START_LEFT |=> left_q == start_left_q)
		else $error("start left not placed");

	a_start_top: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == REG_START_TOP |=> top_q == start_top_q)
		else $error("start top not placed");

endmodule
